[rtl/rhsv_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
package rhsv_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned Q_W    = 16;
  localparam int unsigned HDIV_W = 11;
  localparam int unsigned NUM_W  = 12;
  localparam int unsigned SDIV_W = CHAN_W + Q_W;

  // Payload carried from one division cell to the next.
  typedef struct packed {
    logic              black;
    logic              gray;
    logic [CHAN_W-1:0] mx;
    logic [HDIV_W-1:0] hdiv;
    logic [HDIV_W-1:0] hrem;
    logic [Q_W-1:0]    hq;
    logic [CHAN_W-1:0] srem;
    logic [Q_W-1:0]    slo;
    logic [Q_W-1:0]    sq;
  } stage_t;

endpackage

[rtl/rhsv_front.sv]
// Front stage: channel max and min, sector numerator and divider setup.
module rhsv_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [rhsv_pkg::CHAN_W-1:0]  in_r,
  input  logic [rhsv_pkg::CHAN_W-1:0]  in_g,
  input  logic [rhsv_pkg::CHAN_W-1:0]  in_b,
  output logic                         out_vld,
  output rhsv_pkg::stage_t             out_stage
);
  import rhsv_pkg::*;

  logic              vld_r;
  stage_t            stage_r;
  stage_t            stage_nxt;
  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] delta;
  logic [HDIV_W-1:0] d6;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  num_fix;
  logic [SDIV_W-1:0] sdvd;
  logic              red_max;
  logic              green_max;

  always_comb begin
    red_max   = (in_r >= in_g) && (in_r >= in_b);
    green_max = (in_g >= in_b);
    mx = red_max ? in_r : (green_max ? in_g : in_b);
    if ((in_r <= in_g) && (in_r <= in_b)) begin
      mn = in_r;
    end else if (in_g <= in_b) begin
      mn = in_g;
    end else begin
      mn = in_b;
    end
    delta = mx - mn;
    d6 = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

    // Numerators are formed in two's complement; the top bit flags a negative value.
    if (red_max) begin
      num = {4'h0, in_g} - {4'h0, in_b};
    end else if (green_max) begin
      num = {3'b000, delta, 1'b0} + {4'h0, in_b} - {4'h0, in_r};
    end else begin
      num = {2'b00, delta, 2'b00} + {4'h0, in_r} - {4'h0, in_g};
    end
    num_fix = num[NUM_W-1] ? (num + {1'b0, d6}) : num;

    sdvd = {delta, {Q_W{1'b0}}} - {{Q_W{1'b0}}, delta};

    stage_nxt.black = (mx == '0);
    stage_nxt.gray  = (delta == '0);
    stage_nxt.mx    = mx;
    stage_nxt.hdiv  = d6;
    stage_nxt.hrem  = num_fix[HDIV_W-1:0];
    stage_nxt.hq    = '0;
    stage_nxt.srem  = sdvd[SDIV_W-1:Q_W];
    stage_nxt.slo   = sdvd[Q_W-1:0];
    stage_nxt.sq    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

endmodule

[rtl/rhsv_div_cell.sv]
// One restoring division cell: one quotient bit of hue and of saturation.
module rhsv_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  rhsv_pkg::stage_t in_stage,
  output logic             out_vld,
  output rhsv_pkg::stage_t out_stage
);
  import rhsv_pkg::*;

  logic              vld_r;
  stage_t            stage_r;
  stage_t            stage_nxt;
  logic [HDIV_W:0]   hsh;
  logic [CHAN_W:0]   ssh;
  logic              hbit;
  logic              sbit;
  logic [HDIV_W:0]   hsub;
  logic [CHAN_W:0]   ssub;

  always_comb begin
    hsh  = {in_stage.hrem, 1'b0};
    hbit = (hsh >= {1'b0, in_stage.hdiv});
    hsub = hsh - {1'b0, in_stage.hdiv};
    ssh  = {in_stage.srem, in_stage.slo[Q_W-1]};
    sbit = (ssh >= {1'b0, in_stage.mx});
    ssub = ssh - {1'b0, in_stage.mx};

    stage_nxt      = in_stage;
    stage_nxt.hrem = hbit ? hsub[HDIV_W-1:0] : hsh[HDIV_W-1:0];
    stage_nxt.hq   = {in_stage.hq[Q_W-2:0], hbit};
    stage_nxt.srem = sbit ? ssub[CHAN_W-1:0] : ssh[CHAN_W-1:0];
    stage_nxt.slo  = {in_stage.slo[Q_W-2:0], 1'b0};
    stage_nxt.sq   = {in_stage.sq[Q_W-2:0], sbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

`ifndef NO_ASSERTIONS
  a_hrem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_stage.gray) |-> (out_stage.hrem < out_stage.hdiv))
    else $error("hue remainder not below divisor");
  a_srem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && !out_stage.black) |-> (out_stage.srem < out_stage.mx))
    else $error("saturation remainder not below divisor");
  a_gray_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && out_stage.black) |-> out_stage.gray)
    else $error("black pixel not flagged gray");
`endif

endmodule

[rtl/rgb_to_hsv_convert_core.sv]
// Top level of the RGB to HSV converter: front stage, division cell chain, result register.
//
// Usage: a pixel transaction is taken at each rising clock edge where start is high
// and busy is low. busy is always low, so a new pixel may be offered in every cycle
// and the block sustains one pixel per clock.
// Each transaction yields exactly one result, shown on out_hue, out_saturation and
// out_brightness for one cycle with out_valid high; the receiver takes it at the edge
// that ends that cycle and cannot hold it off.
// Pipeline: the front stage (max, min, sector numerator) loads at the accepting edge
// itself, each of the 16 division cells then settles one quotient bit of hue and of
// saturation, and the result register follows; out_valid rises as it loads.
// The length of the cell chain is set by the 16-bit quotients.
// Reset (rst_n low, synchronous) clears every valid flag in the pipeline, so
// transactions in flight are dropped and no result appears until new ones arrive.
// Brightness is the largest channel; saturation is floor(delta*65535/max), zero for
// black; hue is floor(N*65536/(6*delta)) as a fraction of a turn, zero for gray.
module rgb_to_hsv_convert_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [rhsv_pkg::CHAN_W-1:0] in_red,
  input  logic [rhsv_pkg::CHAN_W-1:0] in_green,
  input  logic [rhsv_pkg::CHAN_W-1:0] in_blue,
  output logic                        out_valid,
  output logic [rhsv_pkg::Q_W-1:0]    out_hue,
  output logic [rhsv_pkg::Q_W-1:0]    out_saturation,
  output logic [rhsv_pkg::CHAN_W-1:0] out_brightness
);
  import rhsv_pkg::*;

  // Element 0 is the front stage output; element k+1 is the output of cell k.
  logic   vld [Q_W+1];
  stage_t stg [Q_W+1];

  logic              out_valid_r;
  logic [Q_W-1:0]    hue_r;
  logic [Q_W-1:0]    hue_nxt;
  logic [Q_W-1:0]    sat_r;
  logic [Q_W-1:0]    sat_nxt;
  logic [CHAN_W-1:0] bri_r;

  // The pipeline never stalls, so a transaction is accepted whenever start is high.
  assign busy = 1'b0;

  rhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start),
    .in_r      (in_red),
    .in_g      (in_green),
    .in_b      (in_blue),
    .out_vld   (vld[0]),
    .out_stage (stg[0])
  );

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    rhsv_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (vld[k]),
      .in_stage  (stg[k]),
      .out_vld   (vld[k+1]),
      .out_stage (stg[k+1])
    );
  end

  // Gray pixels run through the cells with a zero hue divisor and black pixels with a zero
  // saturation divisor; those quotients are meaningless and are replaced by zero here.
  always_comb begin
    hue_nxt = stg[Q_W].gray  ? '0 : stg[Q_W].hq;
    sat_nxt = stg[Q_W].black ? '0 : stg[Q_W].sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    hue_r <= hue_nxt;
    sat_r <= sat_nxt;
    bri_r <= stg[Q_W].mx;
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bri_r;

`ifndef NO_ASSERTIONS
  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_brightness == '0)) |-> ((out_saturation == '0) && (out_hue == '0)))
    else $error("black pixel with nonzero hue or saturation");
  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_saturation == '0)) |-> (out_hue == '0))
    else $error("gray pixel with nonzero hue");
  a_color_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[Q_W] && !stg[Q_W].gray) |-> (stg[Q_W].sq != '0))
    else $error("colored pixel left cell chain with zero saturation");
`endif

endmodule
